// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the costmap smoothing RTL.
// Needs nothing else; bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CSM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("costmap smoothing assertion failed");
`define CSM_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("costmap smoothing reset assertion failed");
`else
`define CSM_ASSERT(lbl, clk, rst_n, prop)
`define CSM_ASSERT_RST(lbl, clk, prop)
`endif
`endif

// ===== rtl/csm_pkg.sv =====
// Package for costmap temporal smoothing: sizes, constants and types.
// Used by csm_cell_store, csm_update and costmap_temporal_smoothing.
package csm_pkg;

  localparam int CELL_COUNT = 1024;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int IDX_W      = 10;
  localparam int EXT_W      = ((IDX_W > ADDR_W) ? IDX_W : ADDR_W) + 1;

  localparam int COST_W  = 8;
  localparam int Q_W     = 15;
  localparam int HOLD_W  = 8;
  localparam int ALPHA_W = 9;
  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_ALPHA = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_FRAMES = CFG_IDX_W'(1);

  localparam logic [ALPHA_W-1:0] Q_ONE         = 9'd256;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET   = 9'd77;
  localparam logic [HOLD_W-1:0]  HOLD_RESET    = 8'd3;
  localparam logic [6:0]         COST_LETHAL   = 7'd100;
  localparam logic [6:0]         COST_SHOW_MAX = 7'd99;
  localparam logic [Q_W-1:0]     COST_HIGH_Q   = 15'd12800;
  localparam logic [Q_W-1:0]     COST_LETHAL_Q = 15'd25600;
  localparam logic [COST_W-1:0]  OUT_UNKNOWN   = 8'hFF;

  typedef struct packed {
    logic [Q_W-1:0]    cost;
    logic              valid;
    logic [HOLD_W-1:0] hold;
  } cell_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    cell_t             data;
  } wr_req_t;

  typedef struct packed {
    logic clear_busy;
  } store_stat_t;

  typedef struct packed {
    logic              wr_en;
    cell_t             entry;
    logic [COST_W-1:0] cost_out;
  } upd_res_t;

endpackage

// ===== rtl/costmap_temporal_smoothing.sv =====
// Costmap temporal smoothing: one cell in, one smoothed cost out, per transfer.
// Takes one cell every cycle unless the output stalls or the clear runs; each result
// goes through the memory read and the read-modify-write stage to the output register.
// Cells of the same index back to back are forwarded from the write-back. After reset
// the cell memory's CELL_COUNT (1024) entries are cleared one by one with in_ready low;
// configuration writes are taken throughout. Depends on csm_pkg, csm_cell_store,
// csm_update and assert_macros.svh.
`include "assert_macros.svh"

module costmap_temporal_smoothing (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [csm_pkg::IDX_W-1:0]         in_cell_index,
  input  logic signed [csm_pkg::COST_W-1:0] in_cost_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [csm_pkg::COST_W-1:0] out_cost_out,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [csm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [csm_pkg::ALPHA_W-1:0]       cfg_data
);

  logic [csm_pkg::ALPHA_W-1:0] alpha_r;
  logic [csm_pkg::HOLD_W-1:0]  hold_frames_r;

  logic                        in_xfer;
  logic [csm_pkg::EXT_W-1:0]   idx_ext;
  logic                        idx_in_range;
  logic [csm_pkg::ADDR_W-1:0]  idx_addr;

  logic                        s1_valid_r;
  logic                        s1_in_range_r;
  logic [csm_pkg::COST_W-1:0]  s1_cost_r;
  logic [csm_pkg::ADDR_W-1:0]  s1_addr_r;
  logic                        s1_adv;
  logic                        fwd_hit_r;
  csm_pkg::cell_t              fwd_data_r;

  logic                        out_valid_r;
  logic [csm_pkg::COST_W-1:0]  out_cost_r;

  csm_pkg::rd_req_t            rd;
  csm_pkg::wr_req_t            wr;
  csm_pkg::cell_t              rd_data;
  csm_pkg::cell_t              prev;
  csm_pkg::store_stat_t        stat;
  csm_pkg::upd_res_t           upd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r       <= csm_pkg::ALPHA_RESET;
      hold_frames_r <= csm_pkg::HOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        csm_pkg::CFG_BLEND_ALPHA: begin
          alpha_r <= (cfg_data > csm_pkg::Q_ONE) ? csm_pkg::Q_ONE : cfg_data;
        end
        csm_pkg::CFG_HOLD_FRAMES: begin
          hold_frames_r <= cfg_data[csm_pkg::HOLD_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign idx_ext      = csm_pkg::EXT_W'(in_cell_index);
  assign idx_in_range = idx_ext < csm_pkg::EXT_W'(csm_pkg::CELL_COUNT);
  assign idx_addr     = idx_ext[csm_pkg::ADDR_W-1:0];

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !stat.clear_busy && (!s1_valid_r || s1_adv);
  assign in_xfer  = in_valid && in_ready;

  assign rd.en   = in_xfer;
  assign rd.addr = idx_addr;

  assign prev = fwd_hit_r ? fwd_data_r : rd_data;

  csm_update u_update (
    .in_range    (s1_in_range_r),
    .cost        (s1_cost_r),
    .prev        (prev),
    .alpha       (alpha_r),
    .hold_frames (hold_frames_r),
    .res         (upd)
  );

  assign wr.en   = s1_adv && upd.wr_en;
  assign wr.addr = s1_addr_r;
  assign wr.data = upd.entry;

  csm_cell_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd      (rd),
    .wr      (wr),
    .rd_data (rd_data),
    .stat    (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_in_range_r <= idx_in_range;
      s1_cost_r     <= in_cost_in;
      s1_addr_r     <= idx_addr;
      fwd_hit_r     <= wr.en && (wr.addr == idx_addr);
      fwd_data_r    <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_cost_r <= upd.cost_out;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_cost_out = out_cost_r;

  `CSM_ASSERT_RST(a_reset_empties_output, clk, !rst_n |=> !out_valid_r)
  `CSM_ASSERT(a_clear_blocks_input, clk, rst_n, stat.clear_busy |-> !in_ready)
  `CSM_ASSERT(a_write_from_stage, clk, rst_n, wr.en |-> s1_valid_r && s1_in_range_r)
  `CSM_ASSERT(a_stall_holds_stage, clk, rst_n,
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_addr_r))

endmodule

// ===== rtl/csm_cell_store.sv =====
// Per-cell state memory with one read and one write port, read data registered.
// Clears every entry after reset, one a cycle. Depends on csm_pkg.
module csm_cell_store (
  input  logic                  clk,
  input  logic                  rst_n,
  input  csm_pkg::rd_req_t      rd,
  input  csm_pkg::wr_req_t      wr,
  output csm_pkg::cell_t        rd_data,
  output csm_pkg::store_stat_t  stat
);

  csm_pkg::cell_t mem [csm_pkg::CELL_COUNT];
  csm_pkg::cell_t rd_data_r;

  logic [csm_pkg::ADDR_W-1:0] clr_addr_r;
  logic                       clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == csm_pkg::ADDR_W'(csm_pkg::CELL_COUNT - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data         = rd_data_r;
  assign stat.clear_busy = clr_busy_r;

endmodule

// ===== rtl/csm_update.sv =====
// Cell update: classify the raw cost, blend, decay or replay, and form the result.
// Pure logic between the read stage and the write-back. Depends on csm_pkg.
module csm_update (
  input  logic                           in_range,
  input  logic signed [csm_pkg::COST_W-1:0] cost,
  input  csm_pkg::cell_t                 prev,
  input  logic [csm_pkg::ALPHA_W-1:0]    alpha,
  input  logic [csm_pkg::HOLD_W-1:0]     hold_frames,
  output csm_pkg::upd_res_t              res
);

  logic                        is_unknown;
  logic                        is_lethal;
  logic [6:0]                  cost7;
  logic [csm_pkg::ALPHA_W-1:0] one_minus_a;
  logic [23:0]                 decay_prod;
  logic [csm_pkg::Q_W-1:0]     decay_q;
  logic [15:0]                 meas_prod;
  logic [16:0]                 blend_sum;
  logic [csm_pkg::Q_W-1:0]     blend_q;
  logic [6:0]                  prev_int;
  logic [6:0]                  blend_int;
  logic [6:0]                  decay_int;

  assign is_unknown  = cost[7];
  assign cost7       = cost[6:0];
  assign is_lethal   = !cost[7] && (cost7 >= csm_pkg::COST_LETHAL);
  assign one_minus_a = csm_pkg::Q_ONE - alpha;
  assign decay_prod  = 24'(prev.cost) * 24'(one_minus_a);
  assign decay_q     = decay_prod[22:8];
  assign meas_prod   = 16'(alpha) * 16'(cost7);
  assign blend_sum   = 17'(meas_prod) + 17'(decay_q);
  assign blend_q     = prev.valid ? blend_sum[14:0] : {cost7, 8'd0};
  assign prev_int    = prev.cost[14:8];
  assign blend_int   = blend_q[14:8];
  assign decay_int   = decay_q[14:8];

  always_comb begin
    res.wr_en    = 1'b0;
    res.entry    = prev;
    res.cost_out = csm_pkg::OUT_UNKNOWN;
    priority if (!in_range) begin
      res.wr_en = 1'b0;
    end else if (is_lethal) begin
      res.wr_en       = 1'b1;
      res.entry.cost  = csm_pkg::COST_LETHAL_Q;
      res.entry.valid = 1'b1;
      res.entry.hold  = hold_frames;
      res.cost_out    = {1'b0, csm_pkg::COST_LETHAL};
    end else if (is_unknown) begin
      priority if (prev.hold != '0) begin
        res.wr_en      = 1'b1;
        res.entry.hold = prev.hold - 1'b1;
        res.cost_out   = {1'b0, (prev_int > csm_pkg::COST_LETHAL) ?
                                 csm_pkg::COST_LETHAL : prev_int};
      end else if (prev.valid) begin
        res.wr_en      = 1'b1;
        res.entry.cost = decay_q;
        res.cost_out   = {1'b0, (decay_int > csm_pkg::COST_SHOW_MAX) ?
                                 csm_pkg::COST_SHOW_MAX : decay_int};
      end else begin
        res.cost_out = csm_pkg::OUT_UNKNOWN;
      end
    end else begin
      res.wr_en       = 1'b1;
      res.entry.cost  = blend_q;
      res.entry.valid = 1'b1;
      res.entry.hold  = (blend_q > csm_pkg::COST_HIGH_Q) ? hold_frames : '0;
      res.cost_out    = {1'b0, (blend_int > csm_pkg::COST_SHOW_MAX) ?
                                csm_pkg::COST_SHOW_MAX : blend_int};
    end
  end

endmodule
